>>> rtl/assert_macros.svh
// Assertion macros shared by the shelf packer RTL.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/gasp_pkg.sv
// Types and fixed constants for the glyph atlas shelf packer.
// Depends on nothing; imported by the top level.
package gasp_pkg;

  localparam int unsigned DIM_W    = 8;  // glyph width and height
  localparam int unsigned PAGE_W   = 4;  // reported page index
  localparam int unsigned POS_W    = 9;  // reported x and y
  localparam int unsigned GAP      = 2;  // gap between glyphs and shelves
  localparam int unsigned MARGIN   = 1;  // margin at the top-left of a page

  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              opened_page;
    logic              out_of_pages;
  } res_t;

endpackage

>>> rtl/glyph_atlas_shelf_packer.sv
// Glyph atlas shelf packer: places glyph rectangles on square atlas pages.
// Depends on gasp_pkg and assert_macros.svh.
//
//   Channel  Ports                                  Direction  Carries
//   input    in_valid, in_stall, in_glyph_*         in         one glyph size
//   result   out_valid, out_stall, out_*            out        page, x, y, flags
//
// One glyph is accepted in every cycle while in_stall is low. Its result is
// presented once it has passed the input register and the result register.
// The rate is set by the single placement stage between the input register and
// the result register, which also updates the packing state in the same cycle.
// Reset (rst_n low at a rising edge) empties both registers and returns the
// state to cursor (1,1), shelf height 0 and no page open.
// A stalled result holds; in_stall rises only when both registers are full and
// the result is stalled.
`include "assert_macros.svh"

module glyph_atlas_shelf_packer #(
  parameter int unsigned ATLAS_SIDE = 512,
  parameter int unsigned MAX_PAGES  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gasp_pkg::DIM_W-1:0]  in_glyph_width,
  input  logic [gasp_pkg::DIM_W-1:0]  in_glyph_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gasp_pkg::PAGE_W-1:0] out_page_index,
  output logic [gasp_pkg::POS_W-1:0]  out_pos_x,
  output logic [gasp_pkg::POS_W-1:0]  out_pos_y,
  output logic                        out_opened_page,
  output logic                        out_out_of_pages
);
  import gasp_pkg::*;

  // Coordinate arithmetic width: a cursor stays below the page side, or below
  // a few hundred after a wide glyph wraps, so the side plus 1024 covers every
  // sum formed below.
  localparam int unsigned AW  = $clog2(ATLAS_SIDE + 1024);
  // Page count width, and a wider one for the count plus up to two new pages.
  localparam int unsigned PW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned PSW = $clog2(MAX_PAGES + 3) + PAGE_W;

  localparam logic [AW-1:0]  SIDE_C   = AW'(ATLAS_SIDE);
  localparam logic [AW-1:0]  GAP_C    = AW'(GAP);
  localparam logic [AW-1:0]  MARGIN_C = AW'(MARGIN);
  localparam logic [PSW-1:0] MAXP_C   = PSW'(MAX_PAGES);

  // Input register.
  logic               in_vld_r;
  logic [DIM_W-1:0]   w_r;
  logic [DIM_W-1:0]   h_r;

  // Packing state.
  logic [AW-1:0]      cursor_x_r, cursor_x_nxt;
  logic [AW-1:0]      cursor_y_r, cursor_y_nxt;
  logic [DIM_W-1:0]   shelf_height_r, shelf_height_nxt;
  logic [PW-1:0]      pages_open_r, pages_open_nxt;

  // Result register.
  logic               out_vld_r;
  res_t               res_r, res_nxt;

  logic               in_take;
  logic               move;

  // The placement stage moves when it holds a glyph and the result register is
  // free or being emptied in this cycle.
  assign move     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Placement: the shelf steps of the algorithm, each a narrow add and compare.
  logic [DIM_W-1:0]   tallest;
  logic               open_first, wrap, open_second, refuse;
  logic [AW-1:0]      cx1, cy1, cx2, cy2, cx3, cy3;
  logic [DIM_W-1:0]   sh1, sh2, sh3;
  logic [PSW-1:0]     pages_sum;
  logic [PSW-1:0]     page_last;

  always_comb begin
    tallest    = (shelf_height_r > h_r) ? shelf_height_r : h_r;
    // A first page, or the tallest glyph no longer fits under the current shelf.
    open_first = (pages_open_r == '0) ||
                 ((cursor_y_r + AW'(tallest) + GAP_C) >= SIDE_C);
    cx1 = open_first ? MARGIN_C : cursor_x_r;
    cy1 = open_first ? MARGIN_C : cursor_y_r;
    sh1 = open_first ? '0 : shelf_height_r;

    // The row is full: start a new shelf below the current one.
    wrap = (cx1 + AW'(w_r) + GAP_C) >= SIDE_C;
    cx2  = wrap ? MARGIN_C : cx1;
    cy2  = wrap ? (cy1 + AW'(sh1) + GAP_C) : cy1;
    sh2  = wrap ? '0 : sh1;

    // The new shelf runs past the bottom of the page: take another page.
    open_second = (cy2 + AW'(h_r) + GAP_C) >= SIDE_C;
    cx3 = open_second ? MARGIN_C : cx2;
    cy3 = open_second ? MARGIN_C : cy2;
    sh3 = open_second ? '0 : sh2;

    pages_sum = PSW'(pages_open_r) + PSW'(open_first) + PSW'(open_second);
    refuse    = pages_sum > MAXP_C;
    page_last = pages_sum - PSW'(1);

    // Refused glyphs leave the state alone and report zero fields.
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    shelf_height_nxt = shelf_height_r;
    pages_open_nxt   = pages_open_r;
    res_nxt          = '0;
    if (refuse) begin
      res_nxt.out_of_pages = 1'b1;
    end else begin
      cursor_x_nxt        = cx3 + AW'(w_r) + GAP_C;
      cursor_y_nxt        = cy3;
      shelf_height_nxt    = (sh3 > h_r) ? sh3 : h_r;
      pages_open_nxt      = pages_sum[PW-1:0];
      res_nxt.page_index  = page_last[PAGE_W-1:0];
      res_nxt.pos_x       = cx3[POS_W-1:0];
      res_nxt.pos_y       = cy3[POS_W-1:0];
      res_nxt.opened_page = open_first || open_second;
    end
  end

  // Control and packing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      cursor_x_r     <= MARGIN_C;
      cursor_y_r     <= MARGIN_C;
      shelf_height_r <= '0;
      pages_open_r   <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (move) begin
        in_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r      <= 1'b1;
        cursor_x_r     <= cursor_x_nxt;
        cursor_y_r     <= cursor_y_nxt;
        shelf_height_r <= shelf_height_nxt;
        pages_open_r   <= pages_open_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      w_r <= in_glyph_width;
      h_r <= in_glyph_height;
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_page_index   = res_r.page_index;
  assign out_pos_x        = res_r.pos_x;
  assign out_pos_y        = res_r.pos_y;
  assign out_opened_page  = res_r.opened_page;
  assign out_out_of_pages = res_r.out_of_pages;

  // The page count never passes the number of pages available.
  `ASSERT_CLK(a_pages_bounded, (PSW'(pages_open_r) <= MAXP_C), "page count above limit")
  // The cursor row always lies inside the page.
  `ASSERT_CLK(a_row_in_page, (cursor_y_r < SIDE_C), "cursor row outside page")
  // A placed glyph implies that at least one page is open.
  `ASSERT_IMPLY(a_placed_has_page, (out_vld_r && !res_r.out_of_pages), (pages_open_r != '0), "placed glyph without page")
  // A refused glyph carries all-zero placement fields.
  `ASSERT_IMPLY(a_refused_zero, (out_vld_r && res_r.out_of_pages), ((res_r.pos_x == '0) && (res_r.pos_y == '0) && !res_r.opened_page && (res_r.page_index == '0)), "refused glyph with placement")

endmodule

>>> bench/glyph_atlas_shelf_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for glyph_atlas_shelf_packer: directed and random glyph sizes.
// Depends on gasp_pkg and the packer RTL; predicts every placement in its own model.
module glyph_atlas_shelf_packer_tb;
  import gasp_pkg::*;

  localparam int unsigned ATLAS_SIDE     = 512;
  localparam int unsigned MAX_PAGES      = 16;
  localparam int unsigned RANDOM_GLYPHS  = 1000;
  localparam int unsigned TAIL_GLYPHS    = 210;
  localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES   = 10;    // wait after the last result has been taken
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up

  // Packing state as the bench tracks it. Kept in plain integers so that the
  // intermediate sums of the placement rules never wrap.
  typedef struct {
    int unsigned cur_x;
    int unsigned cur_y;
    int unsigned shelf_h;
    int unsigned pages;
  } shelf_state_t;

  // One glyph waiting to be offered, together with the idling pattern that
  // applies while it is the next transaction in line.
  typedef struct {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int unsigned      idle_pct;
    int unsigned      stall_pct;
    bit               hold;
  } glyph_req_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [DIM_W-1:0]  in_glyph_width   = '0;
  logic [DIM_W-1:0]  in_glyph_height  = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [PAGE_W-1:0] out_page_index;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic              out_opened_page;
  logic              out_out_of_pages;

  glyph_req_t   glyphs_to_send[$];
  res_t         placements_due[$];
  shelf_state_t packer;       // state after every accepted transaction
  shelf_state_t plan_state;   // state as foreseen while the stimulus is built
  int unsigned  recv_stall_pct = 0;
  int unsigned  holds_asked    = 0;
  int unsigned  holds_served   = 0;
  int unsigned  hold_left      = 0;
  int unsigned  quiet_cycles   = 0;
  bit           failed         = 1'b0;

  glyph_atlas_shelf_packer #(
    .ATLAS_SIDE(ATLAS_SIDE),
    .MAX_PAGES (MAX_PAGES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_page_index  (out_page_index),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_opened_page (out_opened_page),
    .out_out_of_pages(out_out_of_pages)
  );

  always #5 clk = ~clk;

  // Shelf placement of one glyph. A page is opened first if none exists or the
  // current shelf, grown to this glyph, would run past the bottom edge. The row
  // then wraps to a new shelf if the glyph does not fit across, and a second
  // page is opened if the wrapped shelf has no room below. Should the opened
  // pages exceed the page budget, the glyph is refused and nothing moves.
  function automatic void place_glyph(input shelf_state_t cur, input int unsigned w,
                                      input int unsigned h, output shelf_state_t nxt,
                                      output res_t res);
    int unsigned cx;
    int unsigned cy;
    int unsigned sh;
    int unsigned opened;
    int unsigned tallest;
    cx      = cur.cur_x;
    cy      = cur.cur_y;
    sh      = cur.shelf_h;
    opened  = 0;
    tallest = (sh > h) ? sh : h;
    if (cur.pages == 0 || cy + tallest + GAP >= ATLAS_SIDE) begin
      opened = opened + 1;
      cx = MARGIN;
      cy = MARGIN;
      sh = 0;
    end
    if (cx + w + GAP >= ATLAS_SIDE) begin
      cx = MARGIN;
      cy = cy + sh + GAP;
      sh = 0;
    end
    if (cy + h + GAP >= ATLAS_SIDE) begin
      opened = opened + 1;
      cx = MARGIN;
      cy = MARGIN;
      sh = 0;
    end
    nxt = cur;
    res = '0;
    if (cur.pages + opened > MAX_PAGES) begin
      res.out_of_pages = 1'b1;
    end else begin
      nxt.pages       = cur.pages + opened;
      nxt.cur_x       = cx + w + GAP;
      nxt.cur_y       = cy;
      nxt.shelf_h     = (sh > h) ? sh : h;
      res.page_index  = PAGE_W'(nxt.pages - 1);
      res.pos_x       = POS_W'(cx);
      res.pos_y       = POS_W'(cy);
      res.opened_page = (opened != 0);
    end
  endfunction

  // Appends a glyph to the stimulus and advances the planning copy of the
  // state, so that later choices can react to how many pages are in use.
  task automatic queue_glyph(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input bit hold);
    glyph_req_t   req;
    shelf_state_t nxt;
    res_t         ignored;
    req.w         = w;
    req.h         = h;
    req.idle_pct  = idle_pct;
    req.stall_pct = stall_pct;
    req.hold      = hold;
    glyphs_to_send = {glyphs_to_send, req};
    place_glyph(plan_state, 32'(w), 32'(h), nxt, ignored);
    plan_state = nxt;
  endtask

  task automatic compare_field(input string name, input logic [POS_W-1:0] expected,
                               input logic [POS_W-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
      failed = 1'b1;
    end
  endtask

  // Stimulus and end of run. The whole glyph list is built up front; the
  // driver below then offers it one transaction at a time.
  initial begin : stimulus
    int unsigned n;
    int unsigned phase;
    int unsigned idle;
    int unsigned stall;
    int unsigned roll;
    int unsigned reach;
    plan_state = '{cur_x: MARGIN, cur_y: MARGIN, shelf_h: 0, pages: 0};

    // Directed glyphs: empty and oversized rectangles, degenerate strips, a
    // row that wraps, tall shelves that force a fresh page, and all-ones and
    // all-zeros on both fields.
    queue_glyph(8'd0,   8'd0,   0, 0, 1'b0);
    queue_glyph(8'd255, 8'd255, 0, 0, 1'b0);
    queue_glyph(8'd255, 8'd0,   0, 0, 1'b0);
    queue_glyph(8'd0,   8'd255, 0, 0, 1'b0);
    queue_glyph(8'd200, 8'd5,   0, 0, 1'b0);
    queue_glyph(8'd200, 8'd5,   0, 0, 1'b0);
    queue_glyph(8'd200, 8'd5,   0, 0, 1'b0);
    queue_glyph(8'd10,  8'd250, 0, 0, 1'b0);
    queue_glyph(8'd10,  8'd250, 0, 0, 1'b0);
    queue_glyph(8'd1,   8'd1,   0, 0, 1'b0);
    queue_glyph(8'd128, 8'd128, 0, 0, 1'b0);
    queue_glyph(8'd254, 8'd254, 0, 0, 1'b0);
    queue_glyph(8'd127, 8'd1,   0, 0, 1'b0);
    queue_glyph(8'd1,   8'd127, 0, 0, 1'b0);
    queue_glyph(8'd85,  8'd170, 0, 0, 1'b0);
    queue_glyph(8'd170, 8'd85,  0, 0, 1'b0);
    queue_glyph(8'd0,   8'd0,   0, 0, 1'b0);
    queue_glyph(8'd255, 8'd255, 0, 0, 1'b0);

    // Random glyphs, mostly small so that pages fill shelf by shelf, with the
    // odd medium or full-range one to break shelves and pages. Once most of
    // the page budget is spent only tiny glyphs are sent, keeping the budget
    // for the exhaustion phase further down. The idling pattern moves through
    // four phases every hundred glyphs, and two glyphs trigger a long hold-off.
    for (n = 0; n < RANDOM_GLYPHS; n++) begin
      phase = (n / 100) % 4;
      idle  = (phase == 1) ? 76 : (phase == 3) ? 6 : 0;
      stall = (phase == 2) ? 76 : (phase == 3) ? 6 : 0;
      roll  = $urandom_range(99);
      if (plan_state.pages >= MAX_PAGES - 3) begin
        reach = 15;
      end else if (roll < 2) begin
        reach = 255;
      end else if (roll < 10) begin
        reach = 127;
      end else begin
        reach = 31;
      end
      queue_glyph(DIM_W'($urandom_range(reach)), DIM_W'($urandom_range(reach)),
                  idle, stall, n == 30 || n == 420);
    end

    // Full-page glyphs take one page each, so this run uses up every page
    // and the last few are refused.
    for (n = 0; n < 20; n++) begin
      queue_glyph(8'd255, 8'd255, 0, 0, 1'b0);
    end

    // With no page left, small glyphs still fill the last page while large
    // ones are refused.
    for (n = 0; n < TAIL_GLYPHS; n++) begin
      phase = (n / 50) % 4;
      idle  = (phase == 1) ? 76 : (phase == 3) ? 6 : 0;
      stall = (phase == 2) ? 76 : (phase == 3) ? 6 : 0;
      reach = ($urandom_range(99) < 50) ? 255 : 31;
      queue_glyph(DIM_W'($urandom_range(reach)), DIM_W'($urandom_range(reach)),
                  idle, stall, 1'b0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling on the falling edge keeps this process clear of the updates
    // that the clocked blocks make on the rising edge.
    while (glyphs_to_send.size() != 0 || in_valid || placements_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver. The payload is only changed when the slot is free, that is when
  // nothing is offered or the offered transaction is taken at this edge, so a
  // stalled glyph holds still. Each accepted glyph is run through the model
  // straight away and its placement is queued for the monitor.
  always @(posedge clk) begin : driver
    glyph_req_t   req;
    shelf_state_t nxt;
    res_t         placed;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_glyph_width  <= '0;
      in_glyph_height <= '0;
      packer = '{cur_x: MARGIN, cur_y: MARGIN, shelf_h: 0, pages: 0};
    end else begin
      if (in_valid && !in_stall) begin
        place_glyph(packer, 32'(in_glyph_width), 32'(in_glyph_height), nxt, placed);
        packer = nxt;
        placements_due = {placements_due, placed};
      end
      if (!in_valid || !in_stall) begin
        if (glyphs_to_send.size() != 0 &&
            $urandom_range(99) >= glyphs_to_send[0].idle_pct) begin
          req = glyphs_to_send.pop_front();
          in_valid        <= 1'b1;
          in_glyph_width  <= req.w;
          in_glyph_height <= req.h;
          recv_stall_pct  <= req.stall_pct;
          if (req.hold) begin
            holds_asked <= holds_asked + 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. A requested hold-off keeps the result channel stalled for a long
  // stretch while the driver keeps offering, which fills the block and makes
  // it stall its input. Otherwise stalls are drawn at the phase's rate.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Monitor and watchdog. Every result transaction is matched with the oldest
  // placement still due. The watchdog ends the run once neither channel has
  // moved for too long.
  always @(posedge clk) begin : monitor
    res_t due;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          $display("%0t: unexpected result, page %0d x %0d y %0d opened %0b refused %0b",
                   $time, out_page_index, out_pos_x, out_pos_y, out_opened_page,
                   out_out_of_pages);
          failed = 1'b1;
        end else begin
          due = placements_due.pop_front();
          compare_field("page_index",   POS_W'(due.page_index),   POS_W'(out_page_index));
          compare_field("pos_x",        due.pos_x,                out_pos_x);
          compare_field("pos_y",        due.pos_y,                out_pos_y);
          compare_field("opened_page",  POS_W'(due.opened_page),  POS_W'(out_opened_page));
          compare_field("out_of_pages", POS_W'(due.out_of_pages), POS_W'(out_out_of_pages));
        end
      end
    end
  end

endmodule
